### rtl/tiel_pkg.sv
// shared types and constants for the terminal input escape line discipline
`timescale 1ns / 1ps

package tiel_pkg;

  localparam int LineCountWidthDefault = 16;
  localparam int QueueDepthDefault     = 4;

  // result kinds
  localparam logic [2:0] KIND_BYTE = 3'd0;
  localparam logic [2:0] KIND_KEY  = 3'd1;
  localparam logic [2:0] KIND_ECHO = 3'd2;
  localparam logic [2:0] KIND_INTR = 3'd3;
  localparam logic [2:0] KIND_STOP = 3'd4;

  // character codes
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_ETX   = 8'h03;
  localparam logic [7:0] CH_SUB   = 8'h1A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_SEMI  = 8'h3B;

  // key codes
  localparam logic [3:0] KC_HOME   = 4'd8;
  localparam logic [3:0] KC_END    = 4'd9;
  localparam logic [3:0] KC_DELETE = 4'd10;

  // what the back end has to emit for one received byte
  typedef enum logic [2:0] {
    OP_NONE,
    OP_BYTE,
    OP_ECHOED,
    OP_NEWLINE,
    OP_BKSP,
    OP_KEY,
    OP_INTR,
    OP_STOP
  } op_t;

  typedef struct packed {
    logic       esc;    // deliver a held ESC first
    op_t        op;
    logic [7:0] value;
    logic [3:0] key;
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
    logic [3:0] key;
    logic       last;
  } res_t;

  typedef logic [2:0] idx_t;

endpackage

### rtl/tiel_queue.sv
// small register queue between the front and back ends
`timescale 1ns / 1ps

module tiel_queue
  import tiel_pkg::*;
#(
  parameter int WIDTH = 16,
  parameter int DEPTH = QueueDepthDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;

  assign full    = (count == CntW'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (rd_en) begin
        rd_ptr <= bump(rd_ptr);
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + CntW'(1);
        2'b01:   count <= count - CntW'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !full || rd_en)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> !empty)
    else $error("queue read while empty");

endmodule

### rtl/tiel_front.sv
// front end: escape parser, mode and line count, at most one command per byte
`timescale 1ns / 1ps

module tiel_front
  import tiel_pkg::*;
#(
  parameter int LINE_COUNT_WIDTH = LineCountWidthDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  input  logic       cfg_write,
  input  logic       cfg_raw_mode,
  output cmd_t       cmd,
  output logic       cmd_push
);

  typedef enum logic [1:0] {
    PH_TEXT,
    PH_ESC,
    PH_CSI
  } phase_t;

  phase_t                      phase;
  phase_t                      phase_next;
  logic [15:0]                 acc;
  logic [15:0]                 acc_next;
  logic [1:0]                  arg_pos;
  logic [1:0]                  arg_pos_next;
  logic [LINE_COUNT_WIDTH-1:0] line_count;
  logic [LINE_COUNT_WIDTH-1:0] line_count_next;
  logic                        raw_mode;
  logic [7:0]                  t;
  logic                        do_text;
  logic                        ctrl;

  always_comb begin
    phase_next      = phase;
    acc_next        = acc;
    arg_pos_next    = arg_pos;
    line_count_next = line_count;
    cmd             = '{esc: 1'b0, op: OP_NONE, value: 8'h00, key: 4'h0};
    do_text         = 1'b0;
    ctrl            = (arg_pos == 2'd1) && (acc == 16'd5);
    t               = rx_byte;

    case (phase)
      PH_ESC: begin
        if (rx_byte == CH_LBRK) begin
          phase_next   = PH_CSI;
          acc_next     = '0;
          arg_pos_next = '0;
        end else begin
          cmd.esc    = 1'b1;
          phase_next = PH_TEXT;
          do_text    = 1'b1;
        end
      end
      PH_CSI: begin
        if (rx_byte >= 8'h30 && rx_byte <= 8'h39) begin
          acc_next = {acc[12:0], 3'b000} + {acc[14:0], 1'b0} + {12'h000, rx_byte[3:0]};
        end else if (rx_byte == CH_SEMI) begin
          if (arg_pos != 2'd2) begin
            arg_pos_next = arg_pos + 2'd1;
          end
          acc_next = '0;
        end else if (rx_byte >= 8'h40 && rx_byte <= CH_TILDE) begin
          phase_next = PH_TEXT;
          case (rx_byte)
            8'h41, 8'h42, 8'h43, 8'h44: begin
              cmd.op  = OP_KEY;
              cmd.key = {1'b0, ctrl, 2'(rx_byte[1:0] - 2'd1)};
            end
            8'h48: begin
              cmd.op  = OP_KEY;
              cmd.key = KC_HOME;
            end
            8'h46: begin
              cmd.op  = OP_KEY;
              cmd.key = KC_END;
            end
            CH_TILDE: begin
              if (arg_pos == 2'd0) begin
                if (acc == 16'd1) begin
                  cmd.op  = OP_KEY;
                  cmd.key = KC_HOME;
                end else if (acc == 16'd3) begin
                  cmd.op  = OP_KEY;
                  cmd.key = KC_DELETE;
                end else if (acc == 16'd4) begin
                  cmd.op  = OP_KEY;
                  cmd.key = KC_END;
                end
              end
            end
            default: cmd.op = OP_NONE;
          endcase
        end
      end
      default: begin
        phase_next = PH_TEXT;
        do_text    = 1'b1;
      end
    endcase

    if (do_text) begin
      if (rx_byte == CH_CR) begin
        t = CH_LF;
      end else if (rx_byte == CH_DEL) begin
        t = CH_BS;
      end
      cmd.value = t;
      if (rx_byte == CH_ESC) begin
        phase_next = PH_ESC;
      end else if (rx_byte == CH_ETX) begin
        cmd.op    = OP_INTR;
        cmd.value = 8'h00;
      end else if (rx_byte == CH_SUB) begin
        cmd.op    = OP_STOP;
        cmd.value = 8'h00;
      end else if (raw_mode) begin
        cmd.op = OP_BYTE;
      end else if (t == CH_BS) begin
        // backspace on an empty line is swallowed
        if (line_count != '0) begin
          cmd.op          = OP_BKSP;
          line_count_next = line_count - LINE_COUNT_WIDTH'(1);
        end
      end else if (t == CH_LF) begin
        cmd.op          = OP_NEWLINE;
        line_count_next = '0;
      end else if (t >= CH_SP && t < CH_DEL) begin
        cmd.op = OP_ECHOED;
        if (line_count != '1) begin
          line_count_next = line_count + LINE_COUNT_WIDTH'(1);
        end
      end else begin
        cmd.op = OP_BYTE;
      end
    end
  end

  assign cmd_push = accept && (cmd.esc || cmd.op != OP_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_TEXT;
      acc        <= '0;
      arg_pos    <= '0;
      line_count <= '0;
      raw_mode   <= 1'b0;
    end else if (cfg_write) begin
      raw_mode   <= cfg_raw_mode;
      line_count <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      acc        <= acc_next;
      arg_pos    <= arg_pos_next;
      line_count <= line_count_next;
    end
  end

  a_arg_pos_sat: assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_CSI && rx_byte == CH_SEMI |=> arg_pos != 2'd0)
    else $error("argument position lost a separator");

endmodule

### rtl/tiel_back.sv
// back end: expands a command into result transactions, one per cycle while results are popped
`timescale 1ns / 1ps

module tiel_back
  import tiel_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       head,
  input  logic       q_empty,
  output logic       q_pop,
  output logic       empty,
  input  logic       pop,
  output logic [2:0] kind,
  output logic [7:0] value,
  output logic [3:0] key,
  output logic       last
);

  logic out_valid;
  idx_t idx;
  res_t res;
  logic load;

  function automatic res_t result_of(input cmd_t c, input idx_t i);
    res_t       r;
    logic [2:0] n;
    idx_t       k;
    r = '{kind: KIND_BYTE, value: 8'h00, key: 4'h0, last: 1'b0};
    case (c.op)
      OP_NONE:    n = 3'd0;
      OP_ECHOED:  n = 3'd2;
      OP_NEWLINE: n = 3'd3;
      OP_BKSP:    n = 3'd4;
      default:    n = 3'd1;
    endcase
    n = n + {2'b00, c.esc};
    k = i - {2'b00, c.esc};
    if (c.esc && i == '0) begin
      r.value = CH_ESC;
    end else begin
      case (c.op)
        OP_BYTE: r.value = c.value;
        OP_ECHOED: begin
          r.kind  = (k == 3'd0) ? KIND_BYTE : KIND_ECHO;
          r.value = c.value;
        end
        OP_NEWLINE: begin
          r.kind  = (k == 3'd0) ? KIND_BYTE : KIND_ECHO;
          r.value = (k == 3'd1) ? CH_CR : CH_LF;
        end
        OP_BKSP: begin
          r.kind  = (k == 3'd0) ? KIND_BYTE : KIND_ECHO;
          r.value = (k == 3'd2) ? CH_SP : CH_BS;
        end
        OP_KEY: begin
          r.kind = KIND_KEY;
          r.key  = c.key;
        end
        OP_INTR: r.kind = KIND_INTR;
        OP_STOP: r.kind = KIND_STOP;
        default: r.kind = KIND_BYTE;
      endcase
    end
    r.last = (i == n - 3'd1);
    return r;
  endfunction

  assign res   = result_of(head, idx);
  assign load  = !out_valid || pop;
  assign q_pop = load && !q_empty && res.last;
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (load) begin
      kind  <= res.kind;
      value <= res.value;
      key   <= res.key;
      last  <= res.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= !q_empty;
      if (!q_empty) begin
        idx <= res.last ? '0 : idx + 3'd1;
      end
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx <= 3'd4)
    else $error("result index past five results");

  a_idx_restart: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> idx == '0)
    else $error("index not restarted after command retired");

  a_last_retires: assert property (@(posedge clk) disable iff (rst)
    load && !q_empty && res.last |-> q_pop)
    else $error("final result loaded without retiring its command");

endmodule

### rtl/terminal_input_escape_line_discipline.sv
// top level of the terminal input escape parser with cooked line discipline
//
//  channel   | direction | handshake           | payload
//  ----------+-----------+---------------------+-----------------------------
//  input     | in        | push / full         | rx_byte
//  result    | out       | pop / empty         | kind, value, key, last
//  config    | in        | cfg_valid/cfg_ready | cfg_raw_mode
//
//  the front end takes one byte per cycle while the command queue has room; a byte
//  producing n results (0 to 5) holds the back end while they pass one at a time through the single result register
//  sustained rate is one result per cycle while results are popped
//  first result of a byte passes through the command queue, then the result register
//  rst (synchronous) clears parser state, line count, raw mode, queue, output
//  input stalls only while the command queue is full; a stalled result
//  holds its register and the front end keeps parsing into the queue
`timescale 1ns / 1ps

module terminal_input_escape_line_discipline
  import tiel_pkg::*;
#(
  parameter int LINE_COUNT_WIDTH = LineCountWidthDefault,
  parameter int QUEUE_DEPTH      = QueueDepthDefault
) (
  input  logic       clk,
  input  logic       rst,
  // input queue side
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte,
  // result queue side
  output logic       empty,
  input  logic       pop,
  output logic [2:0] kind,
  output logic [7:0] value,
  output logic [3:0] key,
  output logic       last,
  // configuration write channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_raw_mode
);

  logic accept;
  logic cfg_write;
  cmd_t cmd;
  logic cmd_push;
  cmd_t head;
  logic q_empty;
  logic q_pop;

  // configuration is always taken; it must only arrive while the block is idle (not enforced here)
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  // an input transaction completes whenever the command queue has room
  assign accept = push && !full;

  // parser, mode and line count; one command per byte that yields results
  tiel_front #(
    .LINE_COUNT_WIDTH(LINE_COUNT_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .rx_byte     (rx_byte),
    .cfg_write   (cfg_write),
    .cfg_raw_mode(cfg_raw_mode),
    .cmd         (cmd),
    .cmd_push    (cmd_push)
  );

  // decouples parsing from result delivery
  tiel_queue #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (cmd_push),
    .wr_data(cmd),
    .full   (full),
    .rd_en  (q_pop),
    .rd_data(head),
    .empty  (q_empty)
  );

  // expands each command into its result transactions
  tiel_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .q_empty(q_empty),
    .q_pop  (q_pop),
    .empty  (empty),
    .pop    (pop),
    .kind   (kind),
    .value  (value),
    .key    (key),
    .last   (last)
  );

endmodule
